[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command and
// operation codes, special character codes and the channel payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] DEFAULT_COLOR_RST = 8'h07;

  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_TAB,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } tcw_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_FILL,
    ST_RDWAIT,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
  } tcw_out_t;

  typedef struct packed {
    tcw_op_e    op;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } tcw_op_t;

endpackage

`default_nettype wire

[rtl/core/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// Input side: accepts transactions, decodes command and control characters
// into operations and saturates read coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic             in_valid_i,
  input  tcw_pkg::tcw_in_t in_data_i,
  output logic             in_stall_o,
  input  logic             q_full_i,
  input  logic             busy_i,
  output logic             push_o,
  output tcw_pkg::tcw_op_t entry_o
);
  import tcw_pkg::*;

  assign in_stall_o = q_full_i | busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    entry_o.char_code = in_data_i.char_code;
    entry_o.col = (int'(in_data_i.read_col) > COLS - 1) ? 7'(COLS - 1) : in_data_i.read_col;
    entry_o.row = (int'(in_data_i.read_row) > ROWS - 1) ? 5'(ROWS - 1) : in_data_i.read_row;
    case (in_data_i.cmd)
      CMD_PUT: begin
        case (in_data_i.char_code)
          CH_LF:   entry_o.op = OP_LF;
          CH_CR:   entry_o.op = OP_CR;
          CH_TAB:  entry_o.op = OP_TAB;
          default: entry_o.op = OP_PUT;
        endcase
      end
      CMD_CLEAR: entry_o.op = OP_CLEAR;
      CMD_READ:  entry_o.op = OP_READ;
      default:   entry_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tcw_fifo.sv]
// ----------------------------------------------------------------------------
// tcw_fifo
// Short operation queue between the decoder and the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcw_pkg::tcw_op_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tcw_pkg::tcw_op_t pop_data_o
);
  import tcw_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDEPTH);

  tcw_op_t         mem_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntFull);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// Execution engine: cell store, cursor, row rotation for scrolling, fill
// sweeps for reset, clear and scroll, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int unsigned COLS      = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              q_valid_i,
  input  tcw_pkg::tcw_op_t  q_data_i,
  output logic              q_pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output tcw_pkg::tcw_out_t out_data_o,
  output logic              busy_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AddrW = $clog2(CELLS);
  localparam int unsigned ColW  = $clog2(COLS);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned ModW  = $clog2(TAB_WIDTH + 1);

  localparam logic [ColW:0]    ColsL    = (ColW + 1)'(COLS);
  localparam logic [RowW:0]    RowsL    = (RowW + 1)'(ROWS);
  localparam logic [RowW-1:0]  RowLast  = RowW'(ROWS - 1);
  localparam logic [AddrW-1:0] AddrCols = AddrW'(COLS);
  localparam logic [AddrW-1:0] ColsM1   = AddrW'(COLS - 1);
  localparam logic [AddrW-1:0] AddrLast = AddrW'(CELLS - 1);
  localparam logic [ModW-1:0]  TabL     = ModW'(TAB_WIDTH);
  localparam logic [ModW-1:0]  TabM1    = ModW'(TAB_WIDTH - 1);

  function automatic logic [RowW-1:0] phys_row(input logic [RowW-1:0] r,
                                               input logic [RowW-1:0] b);
    logic [RowW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= RowsL) begin
      s = s - RowsL;
    end
    return s[RowW-1:0];
  endfunction

  logic [7:0] char_mem  [CELLS];
  logic [7:0] color_mem [CELLS];

  tcw_state_e      state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ModW-1:0] mod_q, mod_d;
  logic [RowW-1:0] base_q, base_d;
  logic [ModW-1:0] cnt_q, cnt_d;
  logic [7:0]      char_q, char_d;
  logic [AddrW-1:0] sweep_q, sweep_d;
  logic [AddrW-1:0] sweep_last_q, sweep_last_d;
  logic [7:0]      fill_color_q, fill_color_d;
  logic            init_q, init_d;
  logic [7:0]      color_q;
  logic [7:0]      cell_char_q, cell_char_d;
  logic [7:0]      cell_color_q, cell_color_d;
  logic            out_valid_q, out_valid_d;
  tcw_out_t        out_q, out_d;
  logic [7:0]      rd_char_q, rd_color_q;

  logic             out_free, pop;
  logic [ColW:0]    col_inc;
  logic             wrap, row_at_end, sweep_end;
  logic [AddrW-1:0] cur_addr, rd_addr, scroll_base, cur_off;
  logic [RowW-1:0]  base_next;
  logic             char_we, color_we, rd_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_char;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign pop         = (state_q == ST_IDLE) & q_valid_i & out_free;
  assign q_pop_o     = pop;
  assign busy_o      = init_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign col_inc     = {1'b0, col_q} + 1'b1;
  assign wrap        = (col_inc == ColsL);
  assign row_at_end  = (row_q == RowLast);
  assign sweep_end   = (sweep_q == sweep_last_q);
  assign cur_addr    = AddrW'(phys_row(row_q, base_q)) * AddrCols + AddrW'(col_q);
  assign rd_addr     = AddrW'(phys_row(RowW'(q_data_i.row), base_q)) * AddrCols
                     + AddrW'(q_data_i.col);
  assign scroll_base = AddrW'(base_q) * AddrCols;
  assign base_next   = (base_q == RowLast) ? '0 : base_q + 1'b1;
  assign cur_off     = AddrW'(row_q) * AddrCols + AddrW'(col_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (q_data_i.op)
            OP_PUT, OP_TAB: state_d = ST_PUT;
            OP_LF:          state_d = row_at_end ? ST_FILL : ST_DONE;
            OP_CLEAR:       state_d = ST_FILL;
            OP_READ:        state_d = ST_RDWAIT;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        if (wrap && row_at_end) begin
          state_d = ST_FILL;
        end else if (cnt_q == ModW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        if (sweep_end) begin
          if (init_q) begin
            state_d = ST_IDLE;
          end else if (cnt_q != '0) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RDWAIT: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and store controls
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    mod_d        = mod_q;
    base_d       = base_q;
    cnt_d        = cnt_q;
    char_d       = char_q;
    sweep_d      = sweep_q;
    sweep_last_d = sweep_last_q;
    fill_color_d = fill_color_q;
    init_d       = init_q;
    cell_char_d  = cell_char_q;
    cell_color_d = cell_color_q;
    out_d        = out_q;
    char_we      = 1'b0;
    color_we     = 1'b0;
    rd_en        = 1'b0;
    wr_addr      = cur_addr;
    wr_char      = char_q;
    out_valid_d  = out_valid_q & out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          cell_char_d  = '0;
          cell_color_d = '0;
          cnt_d        = '0;
          case (q_data_i.op)
            OP_PUT: begin
              char_d = q_data_i.char_code;
              cnt_d  = ModW'(1);
            end
            OP_TAB: begin
              char_d = CH_SPACE;
              cnt_d  = TabL - mod_q;
            end
            OP_LF: begin
              if (row_at_end) begin
                sweep_d      = scroll_base;
                sweep_last_d = scroll_base + ColsM1;
                base_d       = base_next;
                fill_color_d = color_q;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
            OP_CR: begin
              col_d = '0;
              mod_d = '0;
            end
            OP_CLEAR: begin
              sweep_d      = '0;
              sweep_last_d = AddrLast;
              fill_color_d = color_q;
              base_d       = '0;
              col_d        = '0;
              row_d        = '0;
              mod_d        = '0;
            end
            OP_READ: rd_en = 1'b1;
            default: ;
          endcase
        end
      end
      ST_PUT: begin
        char_we = 1'b1;
        cnt_d   = cnt_q - 1'b1;
        if (wrap) begin
          col_d = '0;
          mod_d = '0;
          if (row_at_end) begin
            sweep_d      = scroll_base;
            sweep_last_d = scroll_base + ColsM1;
            base_d       = base_next;
            fill_color_d = color_q;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_inc[ColW-1:0];
          mod_d = (mod_q == TabM1) ? '0 : mod_q + 1'b1;
        end
      end
      ST_FILL: begin
        char_we  = 1'b1;
        color_we = 1'b1;
        wr_addr  = sweep_q;
        wr_char  = '0;
        sweep_d  = sweep_q + 1'b1;
        if (sweep_end) begin
          init_d = 1'b0;
        end
      end
      ST_RDWAIT: begin
        cell_char_d  = rd_char_q;
        cell_color_d = rd_color_q;
      end
      ST_DONE: begin
        out_valid_d         = 1'b1;
        out_d.cursor_col    = 7'(col_q);
        out_d.cursor_row    = 5'(row_q);
        out_d.cursor_offset = 11'(cur_off);
        out_d.cell_char     = cell_char_q;
        out_d.cell_color    = cell_color_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      col_q        <= '0;
      row_q        <= '0;
      mod_q        <= '0;
      base_q       <= '0;
      cnt_q        <= '0;
      sweep_q      <= '0;
      sweep_last_q <= AddrLast;
      fill_color_q <= DEFAULT_COLOR_RST;
      init_q       <= 1'b1;
      color_q      <= DEFAULT_COLOR_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      mod_q        <= mod_d;
      base_q       <= base_d;
      cnt_q        <= cnt_d;
      sweep_q      <= sweep_d;
      sweep_last_q <= sweep_last_d;
      fill_color_q <= fill_color_d;
      init_q       <= init_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q       <= char_d;
    cell_char_q  <= cell_char_d;
    cell_color_q <= cell_color_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (rd_en) begin
      rd_char_q <= char_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (color_we) begin
      color_mem[wr_addr] <= fill_color_q;
    end
    if (rd_en) begin
      rd_color_q <= color_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with a character/color cell store and a cursor.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one command per
// transaction: put character, clear screen or read cell. Output channel
// (out_valid_o / out_stall_i / out_data_o): one result per command, in order,
// with the cursor after the command and the read cell (zero otherwise).
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): default color,
// always ready; write it only while the block is idle.
// A two-entry queue decouples command decode from execution, so commands
// are taken while a result waits in the output register.
// In the engine a printable character writes one cell, a tab of n spaces
// writes n cells, a read is a registered store read and a clear sweeps
// every cell through the single store write port; line feed and carriage
// return move the cursor and an unused code changes nothing. A scroll
// blanks one row; rows rotate through a base pointer. After reset a fill
// pass writes every cell with color 7; in_stall_o stays high meanwhile. A
// stalled output holds its result; up to two more commands queue up before
// in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int unsigned COLS      = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcw_pkg::tcw_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);
  import tcw_pkg::*;

  logic    push, q_full, q_valid, q_pop, busy;
  tcw_op_t push_entry, q_entry;

  assign cfg_ready_o = 1'b1;

  tcw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .busy_i    (busy),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  tcw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_entry)
  );

  tcw_back #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_data_i   (q_entry),
    .q_pop_o    (q_pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .busy_o     (busy)
  );

endmodule

`default_nettype wire

[rtl/core/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tcw_pkg::tcw_out_t out_data_o
);
  import tcw_pkg::*;

  logic        in_acc, out_acc;
  logic [2:0]  pend_q, pend_d;
  logic [10:0] exp_off;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;
  assign exp_off = 11'(int'(out_data_o.cursor_row) * COLS + int'(out_data_o.cursor_col));

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_data_o.cursor_col) < COLS)
    else $error("cursor column out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ROWS <= 32) |-> out_data_o.cursor_offset == exp_off)
    else $error("cursor offset does not match cursor position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= 3'd4) && !(out_valid_o && pend_q == 3'd0))
    else $error("result count does not match accepted transactions");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_data_o))
    else $error("result fields unknown");

endmodule

bind text_console_writer tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tcw_checker (.*);

`default_nettype wire

[sim/tb_text_console_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking testbench for the text console writer. A queue-fed driver
// offers put, clear, read and unused commands. A clocked monitor checks
// every result field against a cycle-free screen and cursor model kept in
// this file. The run has three phases with different default colors and
// flow-control mixes, plus one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int unsigned COLS            = 80;
  localparam int unsigned ROWS            = 25;
  localparam int unsigned TAB_WIDTH       = 4;
  localparam int unsigned CELLS           = COLS * ROWS;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 360;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned STALL_LIMIT     = 20000;
  localparam int unsigned DRAIN_CYCLES    = 20;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  tcw_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  tcw_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  tcw_in_t     cmd_backlog[$];
  tcw_out_t    replies_due[$];
  tcw_out_t    reply_want;
  logic [15:0] screen [CELLS];
  int unsigned cur_c, cur_r;
  logic [7:0]  fill_color;
  int unsigned send_idle_pct, recv_idle_pct, phase;
  int unsigned fails, n_queued, n_sent, n_checked;
  int unsigned n_reads, n_clears, n_tabs, n_scrolls;
  int unsigned idle_cycles, hold_left;
  bit          hold_done;

  text_console_writer #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void blank_screen();
    int unsigned i;
    for (i = 0; i < CELLS; i++) begin
      screen[i] = {fill_color, 8'h00};
    end
  endfunction

  function automatic void scroll_screen();
    int unsigned i;
    for (i = 0; i < CELLS - COLS; i++) begin
      screen[i] = screen[i + COLS];
    end
    for (i = CELLS - COLS; i < CELLS; i++) begin
      screen[i] = {fill_color, 8'h00};
    end
    n_scrolls++;
  endfunction

  function automatic void settle_cursor();
    if (cur_c >= COLS) begin
      cur_c = 0;
      cur_r++;
    end
    if (cur_r >= ROWS) begin
      scroll_screen();
      cur_r = ROWS - 1;
    end
  endfunction

  function automatic void put_glyph(input logic [7:0] ch);
    screen[cur_r * COLS + cur_c][7:0] = ch;
    cur_c++;
    settle_cursor();
  endfunction

  function automatic tcw_out_t apply_command(input tcw_in_t cmd_in);
    tcw_out_t    res;
    int unsigned c, r, pad, k;
    res = '0;
    case (cmd_in.cmd)
      CMD_PUT: begin
        case (cmd_in.char_code)
          CH_LF: begin
            cur_r++;
            settle_cursor();
          end
          CH_CR: begin
            cur_c = 0;
            settle_cursor();
          end
          CH_TAB: begin
            pad = TAB_WIDTH - (cur_c % TAB_WIDTH);
            for (k = 0; k < pad; k++) begin
              put_glyph(CH_SPACE);
            end
            n_tabs++;
          end
          default: put_glyph(cmd_in.char_code);
        endcase
      end
      CMD_CLEAR: begin
        blank_screen();
        cur_c = 0;
        cur_r = 0;
        n_clears++;
      end
      CMD_READ: begin
        c = (cmd_in.read_col > COLS - 1) ? COLS - 1 : cmd_in.read_col;
        r = (cmd_in.read_row > ROWS - 1) ? ROWS - 1 : cmd_in.read_row;
        res.cell_char  = screen[r * COLS + c][7:0];
        res.cell_color = screen[r * COLS + c][15:8];
        n_reads++;
      end
      default: ;
    endcase
    res.cursor_col    = 7'(cur_c);
    res.cursor_row    = 5'(cur_r);
    res.cursor_offset = 11'(cur_r * COLS + cur_c);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [10:0] want_v,
                                      input logic [10:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endfunction

  // advance the model on every accepted transaction and offer the next backlog entry
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(apply_command(in_data));
        void'(cmd_backlog.pop_front());
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cmd_backlog[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result with no command outstanding: %p", out_data);
          fails++;
        end else begin
          reply_want = replies_due.pop_front();
          check_field("cursor_col", reply_want.cursor_col, out_data.cursor_col);
          check_field("cursor_row", reply_want.cursor_row, out_data.cursor_row);
          check_field("cursor_offset", reply_want.cursor_offset, out_data.cursor_offset);
          check_field("cell_char", reply_want.cell_char, out_data.cell_char);
          check_field("cell_color", reply_want.cell_color, out_data.cell_color);
          n_checked++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // hold the output once while the sender keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && phase == 3 && in_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_cmd(input logic [1:0] cmd, input logic [7:0] ch,
                          input logic [6:0] col, input logic [4:0] row);
    tcw_in_t t;
    t.cmd       = cmd;
    t.char_code = ch;
    t.read_col  = col;
    t.read_row  = row;
    cmd_backlog.push_back(t);
    n_queued++;
  endtask

  task automatic write_color(input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    fill_color  = value;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || replies_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic push_read(input int unsigned wild_pct);
    if ($urandom_range(99) < wild_pct) begin
      push_cmd(CMD_READ, 8'($urandom_range(255)), 7'($urandom_range(127)),
               5'($urandom_range(31)));
    end else begin
      push_cmd(CMD_READ, 8'($urandom_range(255)), 7'($urandom_range(COLS - 1)),
               5'($urandom_range(ROWS - 1)));
    end
  endtask

  task automatic queue_random(input int unsigned target);
    int unsigned pick, len, k;
    logic [7:0]  ch;
    while (n_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = $urandom_range(1, 30);
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(99);
          if (pick < 5) begin
            ch = CH_TAB;
          end else if (pick < 9) begin
            ch = 8'($urandom_range(255));
          end else begin
            ch = 8'($urandom_range(8'h7e, 8'h20));
          end
          push_cmd(CMD_PUT, ch, 7'($urandom_range(127)), 5'($urandom_range(31)));
          if ($urandom_range(99) < 8) begin
            push_read(10);
          end
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          push_cmd(CMD_PUT, CH_CR, 7'($urandom_range(127)), 5'($urandom_range(31)));
          push_cmd(CMD_PUT, CH_LF, 7'($urandom_range(127)), 5'($urandom_range(31)));
        end else if (pick < 85) begin
          push_cmd(CMD_PUT, CH_LF, 7'($urandom_range(127)), 5'($urandom_range(31)));
        end else if (pick < 95) begin
          push_cmd(CMD_PUT, CH_CR, 7'($urandom_range(127)), 5'($urandom_range(31)));
        end
      end else if (pick < 75) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          push_read(15);
        end
      end else if (pick < 85) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          push_cmd(CMD_PUT, CH_LF, 7'($urandom_range(127)), 5'($urandom_range(31)));
        end
      end else if (pick < 88) begin
        push_cmd(CMD_CLEAR, 8'($urandom_range(255)), 7'($urandom_range(127)),
                 5'($urandom_range(31)));
      end else begin
        push_cmd(2'($urandom_range(3)), 8'($urandom_range(255)),
                 7'($urandom_range(127)), 5'($urandom_range(31)));
      end
    end
  endtask

  initial begin
    fill_color = DEFAULT_COLOR_RST;
    blank_screen();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall !== 1'b0) @(posedge clk_i);

    // phase 1: color 0, slow receiver, directed commands first
    write_color(8'h00);
    phase         = 1;
    send_idle_pct = 38;
    recv_idle_pct = 80;
    push_cmd(CMD_READ, 8'h00, 7'd0, 5'd0);
    push_cmd(CMD_READ, 8'hff, 7'd127, 5'd31);
    push_cmd(CMD_READ, 8'h00, 7'(COLS), 5'(ROWS));
    push_cmd(CMD_PUT, 8'h41, 7'd0, 5'd0);
    push_cmd(CMD_PUT, 8'h00, 7'd127, 5'd31);
    push_cmd(CMD_PUT, 8'hff, 7'd0, 5'd0);
    push_cmd(CMD_PUT, CH_TAB, 7'd0, 5'd0);
    push_cmd(CMD_PUT, CH_TAB, 7'd0, 5'd0);
    push_cmd(CMD_PUT, CH_CR, 7'd0, 5'd0);
    push_cmd(CMD_PUT, CH_LF, 7'd0, 5'd0);
    push_cmd(CMD_PUT, CH_LF, 7'd0, 5'd0);
    push_cmd(CMD_UNUSED, 8'hff, 7'd127, 5'd31);
    push_cmd(CMD_READ, 8'h00, 7'd0, 5'd0);
    push_cmd(CMD_READ, 8'h00, 7'd2, 5'd0);
    push_cmd(CMD_READ, 8'h00, 7'd3, 5'd0);
    push_cmd(CMD_CLEAR, 8'hff, 7'd127, 5'd31);
    push_cmd(CMD_READ, 8'h00, 7'd0, 5'd0);
    push_cmd(CMD_PUT, 8'h5a, 7'd0, 5'd0);
    push_cmd(CMD_PUT, CH_TAB, 7'd0, 5'd0);
    push_cmd(CMD_READ, 8'h00, 7'd3, 5'd0);
    push_cmd(CMD_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
    queue_random(ITEMS_PER_PHASE);
    wait_drained();

    // phase 2: color 255, slow sender
    write_color(8'hff);
    phase         = 2;
    send_idle_pct = 80;
    recv_idle_pct = 38;
    queue_random(2 * ITEMS_PER_PHASE);
    wait_drained();

    // phase 3: random color, no idling, one long output hold-off
    write_color(8'($urandom_range(254, 1)));
    phase         = 3;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(3 * ITEMS_PER_PHASE);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands, %0d results checked: %0d reads, %0d clears, %0d tabs,",
             n_sent, n_checked, n_reads, n_clears, n_tabs);
    $display("%0d scrolls, three default colors and three flow-control mixes.", n_scrolls);
    if (fails == 0 && replies_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
